// ===== src/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
package deq_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned ELEM_WIDTH_DEF = 32;
	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned COUNT_W        = 5;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_UNDERFLOW = 2'd1,
		STATUS_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] front_value;
		logic [VALUE_W-1:0] back_value;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} rsp_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_READ
	} fsm_t;

endpackage

// ===== src/deq_if.sv =====
// Valid/ready channels for queue commands and responses.
interface deq_cmd_if;
	logic          valid;
	logic          ready;
	deq_pkg::cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface deq_rsp_if;
	logic          valid;
	logic          ready;
	deq_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/deq_ram.sv =====
// Ring storage: one write port, two registered read ports with write forwarding.
module deq_ram #(
	parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int unsigned ELEM_WIDTH = deq_pkg::ELEM_WIDTH_DEF,
	localparam int unsigned IDX_W     = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IDX_W-1:0]      waddr,
	input  logic [ELEM_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [IDX_W-1:0]      raddr_a,
	input  logic [IDX_W-1:0]      raddr_b,
	output logic [ELEM_WIDTH-1:0] rdata_a,
	output logic [ELEM_WIDTH-1:0] rdata_b
);

	logic [ELEM_WIDTH-1:0] mem [DEPTH];
	logic [ELEM_WIDTH-1:0] rdata_a_q;
	logic [ELEM_WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Bypass the word being written when a read hits the same slot.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
			rdata_b_q <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ===== src/double_ended_queue.sv =====
// Double-ended queue on a ring buffer held in a synchronous memory.
// A command reads front and back into the registered RAM ports, then fills the output register.
// No new command is taken until its result is loaded into the output register.
// A finished result waits in an output register while the next command is taken.
// Reset clears front pointer, count and handshake state; slot contents stay undefined,
// no clearing pass, so the queue is ready in the first cycle after reset.
module double_ended_queue #(
	parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int unsigned ELEM_WIDTH = deq_pkg::ELEM_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_cmd_if.sink   cmd,
	deq_rsp_if.source rsp
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] t;
		t = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
		return t[IDX_W-1:0];
	endfunction

	deq_pkg::fsm_t    state_q, state_d;
	logic [IDX_W-1:0] first_q, first_d;
	logic [CNT_W-1:0] count_q, count_d;

	deq_pkg::status_t status_d;
	deq_pkg::status_t status_s1;
	logic [CNT_W-1:0] count_s1;

	logic             accept;
	logic             load_rsp;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] first_dec;
	logic [IDX_W-1:0] tail;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [ELEM_WIDTH-1:0] wdata;
	logic [IDX_W-1:0]      raddr_a;
	logic [IDX_W-1:0]      raddr_b;
	logic [ELEM_WIDTH-1:0] rdata_a;
	logic [ELEM_WIDTH-1:0] rdata_b;

	logic          rsp_valid_q;
	deq_pkg::rsp_t rsp_q;

	assign accept    = cmd.valid && cmd.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign first_dec = (first_q == '0) ? IDX_W'(DEPTH - 1) : first_q - 1'b1;
	assign tail      = wrap_idx(SUM_W'(first_q) + SUM_W'(count_q));
	assign wdata     = ELEM_WIDTH'(cmd.data.value);

	// Next pointer, count and status for the command on the port.
	always_comb begin
		first_d  = first_q;
		count_d  = count_q;
		status_d = deq_pkg::STATUS_DONE;
		we       = 1'b0;
		waddr    = tail;
		unique case (cmd.data.operation)
			deq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_d = deq_pkg::STATUS_OVERFLOW;
				end else begin
					first_d = first_dec;
					count_d = count_q + 1'b1;
					we      = accept;
					waddr   = first_dec;
				end
			end
			deq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status_d = deq_pkg::STATUS_OVERFLOW;
				end else begin
					count_d = count_q + 1'b1;
					we      = accept;
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status_d = deq_pkg::STATUS_UNDERFLOW;
				end else begin
					first_d = wrap_idx(SUM_W'(first_q) + SUM_W'(1));
					count_d = count_q - 1'b1;
				end
			end
			deq_pkg::OP_POP_BACK: begin
				if (empty) begin
					status_d = deq_pkg::STATUS_UNDERFLOW;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				status_d = deq_pkg::STATUS_DONE;
			end
		endcase
	end

	// Read the new front and back; the back address is meaningless when empty.
	assign raddr_a = first_d;
	assign raddr_b = wrap_idx(SUM_W'(first_d) + SUM_W'(count_d) - SUM_W'(1));

	deq_ram #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (accept),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deq_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = deq_pkg::FSM_READ;
				end
			end
			deq_pkg::FSM_READ: begin
				if (load_rsp) begin
					state_d = deq_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == deq_pkg::FSM_IDLE);
		load_rsp  = (state_q == deq_pkg::FSM_READ) && (!rsp_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::FSM_IDLE;
			first_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				first_q <= first_d;
				count_q <= count_d;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
	end

	// Hold the word until taken; zero front and back on an empty queue.
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.status      <= status_s1;
			rsp_q.count       <= deq_pkg::COUNT_W'(count_s1);
			rsp_q.is_empty    <= (count_s1 == '0);
			rsp_q.front_value <= (count_s1 == '0) ? '0 : deq_pkg::VALUE_W'(rdata_a);
			rsp_q.back_value  <= (count_s1 == '0) ? '0 : deq_pkg::VALUE_W'(rdata_b);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

// ===== dv/double_ended_queue_test.sv =====
// Self-checking testbench for the double-ended queue: directed table, then random traffic.
`timescale 1ns / 100ps

module double_ended_queue_test;

	localparam int unsigned DEPTH       = deq_pkg::DEPTH_DEF;
	localparam int          N_RANDOM    = 1300;
	localparam int          CALM_ITEMS  = 200;
	localparam int          HOLD_CYCLES = 80;
	localparam int          CYCLE_LIMIT = 400000;

	typedef struct {
		deq_pkg::op_t  op;
		logic [31:0]   val;
		int            reps;
		bit            has_exp;
		deq_pkg::rsp_t exp;
	} step_row_t;

	logic clk;
	logic arst_n;

	deq_cmd_if cmd_ch();
	deq_rsp_if rsp_ch();

	double_ended_queue #(
		.DEPTH      (deq_pkg::DEPTH_DEF),
		.ELEM_WIDTH (deq_pkg::ELEM_WIDTH_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Predicted queue contents
	logic [deq_pkg::VALUE_W-1:0] ring_slot [DEPTH];
	int unsigned                 head_idx;
	int unsigned                 fill_cnt;

	deq_pkg::rsp_t pending_rsp_q[$];
	step_row_t     step_table[$];
	int            fault_count;
	bit            calm;
	bit            hold_pending;
	bit            cur_has_exp;
	deq_pkg::rsp_t cur_exp;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic deq_pkg::rsp_t deque_apply(deq_pkg::op_t op,
			logic [deq_pkg::VALUE_W-1:0] v);
		deq_pkg::rsp_t r;
		r = '0;
		r.status = deq_pkg::STATUS_DONE;
		case (op)
			deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
				if (fill_cnt >= DEPTH) begin
					r.status = deq_pkg::STATUS_OVERFLOW;
				end else if (op == deq_pkg::OP_PUSH_FRONT) begin
					head_idx = (head_idx + DEPTH - 1) % DEPTH;
					ring_slot[head_idx] = v;
					fill_cnt++;
				end else begin
					ring_slot[(head_idx + fill_cnt) % DEPTH] = v;
					fill_cnt++;
				end
			end
			default: begin
				if (fill_cnt == 0) begin
					r.status = deq_pkg::STATUS_UNDERFLOW;
				end else if (op == deq_pkg::OP_POP_FRONT) begin
					head_idx = (head_idx + 1) % DEPTH;
					fill_cnt--;
				end else begin
					fill_cnt--;
				end
			end
		endcase
		if (fill_cnt != 0) begin
			r.front_value = ring_slot[head_idx];
			r.back_value  = ring_slot[(head_idx + fill_cnt - 1) % DEPTH];
		end
		r.count    = fill_cnt[deq_pkg::COUNT_W-1:0];
		r.is_empty = (fill_cnt == 0);
		return r;
	endfunction

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
		fault_count++;
		$display("%0t: %s mismatch: got %h, want %h", $realtime, field, got, want);
	endtask

	task automatic add_row(deq_pkg::op_t op, logic [31:0] val, int reps, bit has_exp,
			deq_pkg::rsp_t exp);
		step_row_t row;
		row.op      = op;
		row.val     = val;
		row.reps    = reps;
		row.has_exp = has_exp;
		row.exp     = exp;
		step_table.push_back(row);
	endtask

	task automatic offer_word(deq_pkg::op_t op, logic [31:0] v, bit has_exp,
			deq_pkg::rsp_t exp);
		// optional idle burst before the word
		if (!calm && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		cmd_ch.valid          = 1'b1;
		cmd_ch.data.operation = op;
		cmd_ch.data.value     = v;
		cur_has_exp           = has_exp;
		cur_exp               = exp;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain_wait();
		cmd_ch.valid = 1'b0;
		while (pending_rsp_q.size() != 0) @(negedge clk);
	endtask

	// Record accepted commands and check accepted results
	always @(posedge clk) begin
		deq_pkg::rsp_t pred;
		deq_pkg::rsp_t got;
		deq_pkg::rsp_t want;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				pred = deque_apply(cmd_ch.data.operation, cmd_ch.data.value);
				pending_rsp_q.push_back(cur_has_exp ? cur_exp : pred);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (pending_rsp_q.size() == 0) begin
					flag_mismatch("unexpected word", got[31:0], 32'h0);
				end else begin
					want = pending_rsp_q.pop_front();
					if (got.status !== want.status)
						flag_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.front_value !== want.front_value)
						flag_mismatch("front_value", got.front_value, want.front_value);
					if (got.back_value !== want.back_value)
						flag_mismatch("back_value", got.back_value, want.back_value);
					if (got.count !== want.count)
						flag_mismatch("count", 32'(got.count), 32'(want.count));
					if (got.is_empty !== want.is_empty)
						flag_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
				end
			end
		end
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready = 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("double_ended_queue_test NOT OK");
		$finish;
	end

	initial begin
		step_row_t    row;
		int           sent;
		int           phase_len;
		int           push_pct;
		int           pick;
		deq_pkg::op_t op;
		logic [31:0]  v;

		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.data     = '0;
		head_idx        = 0;
		fill_cnt        = 0;
		fault_count     = 0;
		calm            = 1'b0;
		hold_pending    = 1'b0;
		cur_has_exp     = 1'b0;
		cur_exp         = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// pops on an empty queue after reset, then the value extremes
		add_row(deq_pkg::OP_POP_FRONT, 32'h0000_0000, 1, 1,
			'{deq_pkg::STATUS_UNDERFLOW, 32'h0, 32'h0, 5'd0, 1'b1});
		add_row(deq_pkg::OP_POP_BACK, 32'hFFFF_FFFF, 1, 1,
			'{deq_pkg::STATUS_UNDERFLOW, 32'h0, 32'h0, 5'd0, 1'b1});
		add_row(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1,
			'{deq_pkg::STATUS_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0});
		add_row(deq_pkg::OP_PUSH_BACK, 32'h0000_0000, 1, 1,
			'{deq_pkg::STATUS_DONE, 32'hFFFF_FFFF, 32'h0, 5'd2, 1'b0});
		add_row(deq_pkg::OP_POP_FRONT, 32'h1234_5678, 1, 1,
			'{deq_pkg::STATUS_DONE, 32'h0, 32'h0, 5'd1, 1'b0});
		add_row(deq_pkg::OP_POP_BACK, 32'h0, 1, 1,
			'{deq_pkg::STATUS_DONE, 32'h0, 32'h0, 5'd0, 1'b1});
		add_row(deq_pkg::OP_POP_FRONT, 32'h0, 1, 1,
			'{deq_pkg::STATUS_UNDERFLOW, 32'h0, 32'h0, 5'd0, 1'b1});
		add_row(deq_pkg::OP_PUSH_BACK, 32'h5555_5555, 1, 0, '0);
		add_row(deq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA, 1, 0, '0);
		add_row(deq_pkg::OP_POP_BACK, 32'h0, 2, 0, '0);
		// fill across the wrap from both ends, then push on full
		add_row(deq_pkg::OP_PUSH_FRONT, 32'h1000_0000, 8, 0, '0);
		add_row(deq_pkg::OP_PUSH_BACK, 32'h2000_0000, 8, 0, '0);
		add_row(deq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF, 1, 0, '0);
		add_row(deq_pkg::OP_PUSH_BACK, 32'h0BAD_F00D, 1, 0, '0);
		add_row(deq_pkg::OP_POP_FRONT, 32'h0, 3, 0, '0);
		add_row(deq_pkg::OP_PUSH_BACK, 32'h3000_0000, 3, 0, '0);
		add_row(deq_pkg::OP_PUSH_BACK, 32'h4000_0000, 1, 0, '0);
		add_row(deq_pkg::OP_POP_BACK, 32'h0, 16, 0, '0);
		add_row(deq_pkg::OP_POP_BACK, 32'h0, 1, 1,
			'{deq_pkg::STATUS_UNDERFLOW, 32'h0, 32'h0, 5'd0, 1'b1});
		add_row(deq_pkg::OP_PUSH_BACK, 32'h8000_0001, 1, 0, '0);
		add_row(deq_pkg::OP_POP_FRONT, 32'h0, 1, 0, '0);

		foreach (step_table[i]) begin
			row = step_table[i];
			for (int r = 0; r < row.reps; r++)
				offer_word(row.op, row.val + r, row.has_exp, row.exp);
		end
		drain_wait();

		// random phases, push-heavy first under a long result hold-off
		sent = 0;
		hold_pending = 1'b1;
		push_pct = 85;
		while (sent < N_RANDOM) begin
			phase_len = $urandom_range(20, 80);
			for (int j = 0; j < phase_len && sent < N_RANDOM; j++) begin
				calm = (sent >= N_RANDOM - CALM_ITEMS);
				if ($urandom_range(0, 99) < push_pct)
					op = deq_pkg::op_t'($urandom_range(0, 1));
				else
					op = deq_pkg::op_t'($urandom_range(2, 3));
				pick = $urandom_range(0, 15);
				if (pick == 0)
					v = 32'h0000_0000;
				else if (pick == 1)
					v = 32'hFFFF_FFFF;
				else
					v = $urandom;
				offer_word(op, v, 1'b0, '0);
				sent++;
			end
			if ($urandom_range(0, 3) == 0)
				drain_wait();
			case ($urandom_range(0, 3))
				0:       push_pct = 85;
				1:       push_pct = 15;
				default: push_pct = 50;
			endcase
		end

		drain_wait();
		repeat (10) @(negedge clk);
		if (fault_count == 0)
			$display("double_ended_queue_test OK");
		else
			$display("double_ended_queue_test NOT OK");
		$finish;
	end

endmodule
